// ===== rtl/efr_pkg.sv =====
// ============================================================================
// efr_pkg
// Shared types and constants for the escaped frame receiver: frame marker
// bytes, buffer sizing and the item/result records passed between modules.
// ============================================================================
package efr_pkg;

    // Frame buffer sizing
    localparam int MAX_FRAME_BYTES = 128;
    localparam int FILL_W          = 8;   // holds 0..MAX_FRAME_BYTES
    localparam int ADDR_W          = 7;   // index into the frame buffer

    // Frame marker bytes
    localparam logic [7:0] ESC_BYTE  = 8'hF4;
    localparam logic [7:0] HDR_END   = 8'hF5;
    localparam logic [7:0] FTR_END   = 8'hFB;
    localparam logic [7:0] TYPE_BYTE = 8'h01;
    localparam logic [7:0] CTRL_BYTE = 8'h40;
    localparam logic [8:0] ENVELOPE  = 9'd9;

    // Configuration reset value
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

    // Request kinds
    localparam logic REQ_LINK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Where the read data of a result comes from
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_HDR0 = 2'd1,
        RD_HDR1 = 2'd2,
        RD_MEM  = 2'd3
    } t_rd_src;

    // One input item
    typedef struct packed {
        logic              req_type;
        logic [7:0]        rx_byte;
        logic [31:0]       now_ms;
        logic [ADDR_W-1:0] read_index;
    } t_efr_item;

    // One result item
    typedef struct packed {
        logic       frame_done;
        logic       frame_ok;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } t_efr_result;

endpackage

// ===== rtl/efr_frame_core.sv =====
// ============================================================================
// efr_frame_core
// Frame assembly state, frame buffer and result register. One item is
// processed per enable; the result is registered at the same edge.
// ============================================================================
module efr_frame_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_en,
    input  efr_pkg::t_efr_item  i_item,
    output efr_pkg::t_efr_result o_result
);

    // Frame buffer; entries 0 and 1 always hold F4 F5 once written, so they
    // are answered from constants and never stored.
    logic [7:0] r_mem [efr_pkg::MAX_FRAME_BYTES];
    logic [7:0] r_mem_q;

    // Configuration
    logic [15:0] r_gap;

    // Frame state
    logic [efr_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [efr_pkg::FILL_W-1:0] r_exp, n_exp;
    logic                       r_esc, n_esc;
    logic [31:0]                r_last, n_last;
    logic [15:0]                r_sum, n_sum;
    logic [7:0]                 r_ck_hi, n_ck_hi;
    logic [7:0]                 r_ck_lo, n_ck_lo;

    // Result register
    logic                       r_done;
    logic                       r_ok;
    logic [7:0]                 r_len;
    efr_pkg::t_rd_src           r_rd_src;

    // Decode of the current link byte
    logic [efr_pkg::FILL_W-1:0] f_e, e_e, nf;
    logic                       esc_e;
    logic [15:0]                sum_e;
    logic                       tmo;
    logic                       decoded;
    logic                       do_store, do_restart, do_hdr, do_close, len_load;
    logic                       sum_add;
    logic                       mem_we;
    logic                       ck_match;
    logic [8:0]                 len_sum;
    logic [7:0]                 b;
    logic [7:0]                 want;
    efr_pkg::t_rd_src           rd_src;

    assign b = i_item.rx_byte;

    // Next-state decode for one link byte
    always_comb begin
        tmo      = (r_fill != '0) && ((i_item.now_ms - r_last) >= {16'b0, r_gap});
        f_e      = tmo ? '0 : r_fill;
        e_e      = tmo ? '0 : r_exp;
        esc_e    = tmo ? 1'b0 : r_esc;
        sum_e    = tmo ? 16'd0 : r_sum;
        nf       = f_e + 8'd1;
        len_sum  = {1'b0, b} + efr_pkg::ENVELOPE;
        want     = (f_e == e_e - 8'd2) ? efr_pkg::ESC_BYTE : efr_pkg::FTR_END;
        decoded    = 1'b0;
        do_store   = 1'b0;
        do_restart = 1'b0;
        do_hdr     = 1'b0;
        do_close   = 1'b0;
        len_load   = 1'b0;
        n_esc      = esc_e;

        if (f_e == '0) begin
            do_restart = 1'b1;
        end else if (f_e == 8'd1) begin
            if (b == efr_pkg::HDR_END) begin
                do_store = 1'b1;
            end else begin
                do_restart = 1'b1;
            end
        end else if ((e_e != '0) && (f_e >= e_e - 8'd2)) begin
            // footer bytes
            if (b != want) begin
                if ((f_e == e_e - 8'd1) && (b == efr_pkg::HDR_END)) begin
                    do_hdr = 1'b1;
                end else begin
                    do_restart = 1'b1;
                end
            end else begin
                do_store = 1'b1;
                do_close = (f_e == e_e - 8'd1);
            end
        end else begin
            // header and body with escape decoding
            decoded = 1'b1;
            if (esc_e) begin
                n_esc = 1'b0;
                if (b != efr_pkg::ESC_BYTE) begin
                    decoded = 1'b0;
                    if (b == efr_pkg::HDR_END) begin
                        do_hdr = 1'b1;
                    end else begin
                        do_restart = 1'b1;
                    end
                end
            end else if (b == efr_pkg::ESC_BYTE) begin
                n_esc   = 1'b1;
                decoded = 1'b0;
            end
            if (decoded) begin
                if (f_e >= efr_pkg::FILL_W'(efr_pkg::MAX_FRAME_BYTES)) begin
                    do_restart = 1'b1;
                end else begin
                    do_store = 1'b1;
                    if (((nf == 8'd3) && (b != efr_pkg::TYPE_BYTE)) ||
                        ((nf == 8'd4) && (b != efr_pkg::CTRL_BYTE))) begin
                        do_restart = 1'b1;
                    end else if (nf == 8'd5) begin
                        if (len_sum > 9'(efr_pkg::MAX_FRAME_BYTES)) begin
                            do_restart = 1'b1;
                        end else begin
                            len_load = 1'b1;
                        end
                    end
                end
            end
        end

        // checksum covers bytes 2 up to the last body byte
        sum_add  = (f_e >= 8'd2) &&
                   ((e_e == '0) || (({1'b0, f_e} + 9'd5) <= {1'b0, e_e}));
        mem_we   = do_store && (f_e >= 8'd2);
        ck_match = (sum_e == {r_ck_hi, r_ck_lo});

        n_fill  = f_e;
        n_exp   = e_e;
        n_sum   = sum_e;
        n_last  = i_item.now_ms;
        n_ck_hi = r_ck_hi;
        n_ck_lo = r_ck_lo;

        if (do_store) begin
            n_fill = nf;
            if (sum_add) begin
                n_sum = sum_e + {8'b0, b};
            end
            if ((e_e != '0) && (f_e == e_e - 8'd4)) begin
                n_ck_hi = b;
            end
            if ((e_e != '0) && (f_e == e_e - 8'd3)) begin
                n_ck_lo = b;
            end
        end
        if (len_load) begin
            n_exp = len_sum[7:0];
        end
        if (do_restart) begin
            n_fill = (b == efr_pkg::ESC_BYTE) ? 8'd1 : 8'd0;
            n_exp  = '0;
            n_esc  = 1'b0;
            n_sum  = 16'd0;
        end
        if (do_hdr) begin
            n_fill = 8'd2;
            n_exp  = '0;
            n_esc  = 1'b0;
            n_sum  = 16'd0;
        end
        if (do_close) begin
            n_fill = '0;
            n_exp  = '0;
            n_esc  = 1'b0;
            n_sum  = 16'd0;
            n_last = 32'd0;
        end
    end

    // Read source for a buffer read request
    always_comb begin
        case (i_item.read_index)
            7'd0:    rd_src = efr_pkg::RD_HDR0;
            7'd1:    rd_src = efr_pkg::RD_HDR1;
            default: rd_src = efr_pkg::RD_MEM;
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= efr_pkg::GAP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_gap <= i_cfg_wdata;
        end
    end

    // Frame state; read requests leave it alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_exp  <= '0;
            r_esc  <= 1'b0;
            r_last <= 32'd0;
            r_sum  <= 16'd0;
        end else if (i_en && (i_item.req_type == efr_pkg::REQ_LINK)) begin
            r_fill <= n_fill;
            r_exp  <= n_exp;
            r_esc  <= n_esc;
            r_last <= n_last;
            r_sum  <= n_sum;
        end
    end

    // Captured checksum bytes
    always_ff @(posedge i_clk) begin
        if (i_en && (i_item.req_type == efr_pkg::REQ_LINK)) begin
            r_ck_hi <= n_ck_hi;
            r_ck_lo <= n_ck_lo;
        end
    end

    // Frame buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_en && (i_item.req_type == efr_pkg::REQ_LINK) && mem_we) begin
            r_mem[f_e[efr_pkg::ADDR_W-1:0]] <= b;
        end
        if (i_en && (i_item.req_type == efr_pkg::REQ_READ)) begin
            r_mem_q <= r_mem[i_item.read_index];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.req_type == efr_pkg::REQ_READ) begin
                r_done   <= 1'b0;
                r_ok     <= 1'b0;
                r_len    <= 8'd0;
                r_rd_src <= rd_src;
            end else begin
                r_done   <= do_close;
                r_ok     <= do_close && ck_match;
                r_len    <= (do_close && ck_match) ? e_e : 8'd0;
                r_rd_src <= efr_pkg::RD_NONE;
            end
        end
    end

    // Result fields
    always_comb begin
        o_result.frame_done   = r_done;
        o_result.frame_ok     = r_ok;
        o_result.frame_length = r_len;
        case (r_rd_src)
            efr_pkg::RD_HDR0: o_result.read_data = efr_pkg::ESC_BYTE;
            efr_pkg::RD_HDR1: o_result.read_data = efr_pkg::HDR_END;
            efr_pkg::RD_MEM:  o_result.read_data = r_mem_q;
            default:          o_result.read_data = 8'd0;
        endcase
    end

endmodule

// ===== rtl/escaped_frame_receiver_unit.sv =====
// ============================================================================
// escaped_frame_receiver_unit
// Assembles escaped serial frames (F4 F5 01 40 len body ck_hi ck_lo F4 FB),
// checks their 16-bit checksum and serves reads of the frame buffer.
// ============================================================================
//
//  channel   | direction | transfer contents
//  ----------+-----------+---------------------------------------------------
//  s stream  | in        | tuser: req_type; tdata: rx_byte, now_ms, read_index
//  m stream  | out       | tdata: frame_done, frame_ok, frame_length, read_data
//  cfg write | in        | gap_timeout_ms
//
//  One item per cycle sustained while the result stream is not stalled; each
//  input transfer passes through the input register, then is decoded into the
//  result register. Throughput is set by the frame buffer's single write and
//  read port, each used at most once per item.
//  Reset is synchronous, active low; it clears the frame state and sets the
//  gap timeout to 100 ms. The buffer is not cleared.
//  A stalled result holds in the output register; the input register still
//  takes a new transfer whenever the item it holds moves on.
//
module escaped_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rx_byte[7:0], now_ms[39:8], read_index[46:40], 0
    input  logic        s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // frame_done[0], frame_ok[1], frame_length[9:2],
                                   // read_data[17:10], 0
);

    efr_pkg::t_efr_item   r_in;
    logic                 r_in_vld;
    logic                 r_out_vld;
    logic                 adv;
    efr_pkg::t_efr_result result;

    // item moves into the result register when that register is free
    assign adv      = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || adv;
    assign m_tvalid = r_out_vld;

    // Input register
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.req_type   <= s_tuser;
            r_in.rx_byte    <= s_tdata[7:0];
            r_in.now_ms     <= s_tdata[39:8];
            r_in.read_index <= s_tdata[46:40];
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Frame logic and result register
    efr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (adv),
        .i_item      (r_in),
        .o_result    (result)
    );

    // Result packing
    assign m_tdata = {6'b0, result.read_data, result.frame_length,
                      result.frame_ok, result.frame_done};

endmodule

// ===== tb/sv/escaped_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// escaped_frame_receiver_unit_tb
// Self-checking bench for the escaped frame receiver. A short table of
// directed link bytes and buffer reads comes first. Random traffic follows:
// mostly well-formed frames with random bodies, some with faults placed
// in them, plus buffer reads and stray bytes. This runs over several gap
// timeout settings, with random stalls on both streams. Every result
// transfer is checked against the directed table's value or an in-bench decoder model.
// ============================================================================
module escaped_frame_receiver_unit_tb;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_ITEMS     = 1800;
    localparam int PHASES           = 5;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int BUF_N            = efr_pkg::MAX_FRAME_BYTES;
    localparam int ENV_N            = int'(efr_pkg::ENVELOPE);

    // DUT-facing signals; those the bench drives are known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;   // rx_byte[7:0], now_ms[39:8], read_index[46:40], 0
    logic        s_tuser     = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;            // frame_done[0], frame_ok[1], frame_length[9:2],
                                     // read_data[17:10], 0

    // One row of the directed table
    typedef struct {
        efr_pkg::t_efr_item   it;
        bit                   typed;
        efr_pkg::t_efr_result want;
    } t_dir_row;

    t_dir_row             dir_rows[$];
    efr_pkg::t_efr_result due_results[$];

    // Decoder model state
    logic [7:0]  frame_mem[BUF_N];
    bit          mem_valid[BUF_N];
    int          fill_n    = 0;
    int          exp_total = 0;
    bit          in_escape = 1'b0;
    logic [31:0] last_ms   = '0;
    logic [15:0] sum16     = '0;
    logic [15:0] gap_ms    = efr_pkg::GAP_TIMEOUT_RST;

    // Bench bookkeeping
    int          fail_count   = 0;
    int          result_no    = 0;
    int          items_sent   = 0;
    int          cycle_count  = 0;
    int          hold_left    = 0;
    int          stall_left   = 0;
    logic        hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    logic        stall_enable = 1'b0;
    bit          sender_idle  = 1'b0;
    logic [31:0] link_ms;

    escaped_frame_receiver_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame decoder model
    // ------------------------------------------------------------------
    function automatic void drop_frame();
        fill_n    = 0;
        exp_total = 0;
        in_escape = 1'b0;
        last_ms   = '0;
        sum16     = '0;
    endfunction

    // abandon; an escape byte survives as the start of the next frame
    function automatic void restart_with(logic [7:0] b);
        drop_frame();
        if (b == efr_pkg::ESC_BYTE) begin
            frame_mem[0] = efr_pkg::ESC_BYTE;
            mem_valid[0] = 1'b1;
            fill_n       = 1;
        end
    endfunction

    function automatic void open_header();
        drop_frame();
        frame_mem[0] = efr_pkg::ESC_BYTE;
        frame_mem[1] = efr_pkg::HDR_END;
        mem_valid[0] = 1'b1;
        mem_valid[1] = 1'b1;
        fill_n       = 2;
    endfunction

    // checksum covers bytes 2 .. len+4 only
    function automatic void keep_byte(logic [7:0] b);
        int i;
        i = fill_n;
        if (i >= 2 && (exp_total == 0 || i + 5 <= exp_total))
            sum16 = sum16 + b;
        if (i < BUF_N) begin
            frame_mem[i] = b;
            mem_valid[i] = 1'b1;
        end
        fill_n = i + 1;
    endfunction

    function automatic efr_pkg::t_efr_result rx_decode_step(efr_pkg::t_efr_item it);
        efr_pkg::t_efr_result r;
        logic [7:0]  b;
        logic [7:0]  want_b;
        logic [31:0] dt;
        logic [15:0] ck;
        bit          decoded;
        bit          ok;
        int          e;
        r = '0;
        b = it.rx_byte;
        if (it.req_type == efr_pkg::REQ_READ) begin
            r.read_data = frame_mem[it.read_index];
            return r;
        end

        dt = it.now_ms - last_ms;
        if (fill_n != 0 && dt >= {16'd0, gap_ms})
            drop_frame();

        if (fill_n == 0) begin
            restart_with(b);
        end else if (fill_n == 1) begin
            if (b == efr_pkg::HDR_END)
                keep_byte(b);
            else
                restart_with(b);
        end else if (exp_total != 0 && fill_n >= exp_total - 2) begin
            // checksum done, expecting the F4 FB footer
            want_b = (fill_n == exp_total - 2) ? efr_pkg::ESC_BYTE : efr_pkg::FTR_END;
            if (b != want_b) begin
                if (fill_n == exp_total - 1 && b == efr_pkg::HDR_END)
                    open_header();
                else
                    restart_with(b);
            end else begin
                keep_byte(b);
                if (fill_n == exp_total) begin
                    e  = exp_total;
                    ck = {frame_mem[(e - 4) % BUF_N],
                          frame_mem[(e - 3) % BUF_N]};
                    ok = (sum16 == ck);
                    drop_frame();
                    r.frame_done   = 1'b1;
                    r.frame_ok     = ok;
                    r.frame_length = ok ? 8'(e) : 8'd0;
                    return r;
                end
            end
        end else begin
            // header and body, with escape decoding
            decoded = 1'b1;
            if (in_escape) begin
                in_escape = 1'b0;
                if (b != efr_pkg::ESC_BYTE) begin
                    if (b == efr_pkg::HDR_END)
                        open_header();
                    else
                        restart_with(b);
                    decoded = 1'b0;
                end
            end else if (b == efr_pkg::ESC_BYTE) begin
                in_escape = 1'b1;
                decoded   = 1'b0;
            end
            if (decoded) begin
                if (fill_n >= BUF_N) begin
                    restart_with(b);
                end else begin
                    keep_byte(b);
                    if ((fill_n == 3 && b != efr_pkg::TYPE_BYTE) ||
                        (fill_n == 4 && b != efr_pkg::CTRL_BYTE)) begin
                        restart_with(b);
                    end else if (fill_n == 5) begin
                        exp_total = int'(b) + ENV_N;
                        if (exp_total > BUF_N)
                            restart_with(b);
                    end
                end
            end
        end
        last_ms = it.now_ms;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR: result %0d: %s", result_no, msg);
    endtask

    task automatic check_result(input logic [23:0] d);
        efr_pkg::t_efr_result got;
        efr_pkg::t_efr_result want;
        got.frame_done   = d[0];
        got.frame_ok     = d[1];
        got.frame_length = d[9:2];
        got.read_data    = d[17:10];
        result_no++;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, data %h", d));
            return;
        end
        want = due_results.pop_front();
        if (got.frame_done !== want.frame_done || got.frame_ok !== want.frame_ok ||
            got.frame_length !== want.frame_length || got.read_data !== want.read_data)
            report_mismatch($sformatf("done %b/%b ok %b/%b len %0d/%0d data %h/%h (got/exp)",
                got.frame_done, want.frame_done, got.frame_ok, want.frame_ok,
                got.frame_length, want.frame_length, got.read_data, want.read_data));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, wait for its transfer, then log what it should produce.
    // s_tvalid stays high on return so back-to-back items need no gap.
    task automatic send_item(input efr_pkg::t_efr_item it, input bit typed = 1'b0,
                             input efr_pkg::t_efr_result want = '0);
        efr_pkg::t_efr_result r;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {1'b0, it.read_index, it.now_ms, it.rx_byte};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        r = rx_decode_step(it);
        due_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic send_link(input logic [7:0] b);
        efr_pkg::t_efr_item it;
        it.req_type   = efr_pkg::REQ_LINK;
        it.rx_byte    = b;
        it.now_ms     = link_ms;
        it.read_index = 7'($urandom);
        send_item(it);
    endtask

    // reads only touch entries the decoder has already written
    task automatic send_reads(input int n);
        efr_pkg::t_efr_item it;
        int                 idx;
        int                 k;
        for (int j = 0; j < n; j++) begin
            idx = $urandom_range(0, BUF_N - 1);
            for (k = 0; k < BUF_N && !mem_valid[idx]; k++)
                idx = (idx + 1) % BUF_N;
            if (k == BUF_N)
                return;
            it.req_type   = efr_pkg::REQ_READ;
            it.rx_byte    = 8'($urandom);
            it.now_ms     = $urandom;
            it.read_index = 7'(idx);
            send_item(it);
        end
    endtask

    // byte spacing that stays under the gap timeout
    function automatic logic [31:0] short_gap();
        if (gap_ms <= 1)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, gap_ms - 1);
        return $urandom_range(0, (gap_ms > 4) ? 3 : gap_ms - 1);
    endfunction

    // One frame on the wire, clean or with a single placed fault, a bad checksum, or both
    task automatic send_frame();
        logic [7:0]  payload[$];
        logic [7:0]  wire_q[$];
        logic [15:0] sum;
        logic [7:0]  b;
        int          len;
        int          roll;
        int          fault;
        int          pos;
        int          late_pos;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            len = BUF_N - ENV_N;
        else if (roll < 12)
            len = $urandom_range(11, BUF_N - ENV_N - 1);
        else
            len = $urandom_range(0, 10);
        fault = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;

        payload = '{efr_pkg::TYPE_BYTE, efr_pkg::CTRL_BYTE, 8'(len)};
        if (fault == 5)
            payload[2] = 8'($urandom_range(BUF_N - ENV_N + 1, 255));
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(0, 5) == 0) ? efr_pkg::ESC_BYTE : 8'($urandom);
            payload.push_back(b);
        end
        sum = '0;
        foreach (payload[i]) sum = sum + payload[i];
        if ($urandom_range(0, 7) == 0)
            sum = sum ^ 16'($urandom_range(1, 65535));
        payload.push_back(sum[15:8]);
        payload.push_back(sum[7:0]);

        // escape every F4 up to and including the checksum
        wire_q = '{efr_pkg::ESC_BYTE, efr_pkg::HDR_END};
        foreach (payload[i]) begin
            wire_q.push_back(payload[i]);
            if (payload[i] == efr_pkg::ESC_BYTE)
                wire_q.push_back(efr_pkg::ESC_BYTE);
        end
        wire_q.push_back(efr_pkg::ESC_BYTE);
        wire_q.push_back(efr_pkg::FTR_END);

        late_pos = -1;
        case (fault)
            1: wire_q[$urandom_range(0, wire_q.size() - 1)] = 8'($urandom);
            2: begin
                // escape followed by a new header or by junk
                pos = $urandom_range(4, wire_q.size() - 3);
                wire_q.insert(pos, ($urandom_range(0, 1) == 1) ? efr_pkg::HDR_END :
                                                                 8'($urandom));
                wire_q.insert(pos, efr_pkg::ESC_BYTE);
            end
            3: wire_q[wire_q.size() - 1] = efr_pkg::HDR_END;
            4: late_pos = $urandom_range(1, wire_q.size() - 1);
            default: ;
        endcase

        if ($urandom_range(0, 9) == 0)
            link_ms = $urandom;
        else
            link_ms = link_ms + $urandom_range(0, 2 * gap_ms);
        foreach (wire_q[i]) begin
            if (i == late_pos)
                link_ms = link_ms + gap_ms + $urandom_range(0, 500);
            else if (i != 0)
                link_ms = link_ms + short_gap();
            send_link(wire_q[i]);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gap_timeout(input logic [15:0] v);
        wait_drain();
        // let the two-stage pipe settle before touching the register
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gap_ms = v;
    endtask

    function automatic void add_row(input logic rt, input logic [7:0] b,
                                    input logic [31:0] t, input logic [6:0] idx,
                                    input bit typed = 1'b0,
                                    input efr_pkg::t_efr_result want = '0);
        t_dir_row row;
        row.it.req_type   = rt;
        row.it.rx_byte    = b;
        row.it.now_ms     = t;
        row.it.read_index = idx;
        row.typed         = typed;
        row.want          = want;
        dir_rows.push_back(row);
    endfunction

    // Directed table: a frame with an escaped F4 body byte whose timestamps
    // wrap past zero, a read back of its checksum byte, then a length over
    // the buffer size, an escaped F5 restarting the header, and a frame with
    // a bad checksum.
    function automatic void build_directed();
        logic [7:0] frame_a[11];
        logic [7:0] frame_b[17];
        frame_a = '{efr_pkg::ESC_BYTE, efr_pkg::HDR_END, efr_pkg::TYPE_BYTE,
                    efr_pkg::CTRL_BYTE, 8'h01, efr_pkg::ESC_BYTE, efr_pkg::ESC_BYTE,
                    8'h01, 8'h36, efr_pkg::ESC_BYTE, efr_pkg::FTR_END};
        frame_b = '{efr_pkg::ESC_BYTE, efr_pkg::HDR_END, efr_pkg::TYPE_BYTE,
                    efr_pkg::CTRL_BYTE, 8'hFF,
                    efr_pkg::ESC_BYTE, efr_pkg::HDR_END, efr_pkg::TYPE_BYTE,
                    efr_pkg::ESC_BYTE, efr_pkg::HDR_END,
                    efr_pkg::TYPE_BYTE, efr_pkg::CTRL_BYTE, 8'h00, 8'h00, 8'h00,
                    efr_pkg::ESC_BYTE, efr_pkg::FTR_END};
        for (int k = 0; k < 10; k++)
            add_row(efr_pkg::REQ_LINK, frame_a[k], 32'hFFFF_FFF8 + k, 7'h7F);
        add_row(efr_pkg::REQ_LINK, frame_a[10], 32'h0000_0002, 7'h7F, 1'b1,
                efr_pkg::t_efr_result'{1'b1, 1'b1, 8'd10, 8'h00});
        add_row(efr_pkg::REQ_READ, 8'hFF, 32'hFFFF_FFFF, 7'd7, 1'b1,
                efr_pkg::t_efr_result'{1'b0, 1'b0, 8'd0, 8'h36});
        for (int k = 0; k < 16; k++)
            add_row(efr_pkg::REQ_LINK, frame_b[k], 32'h8000_0000 + 3 * k, 7'h00);
        add_row(efr_pkg::REQ_LINK, frame_b[16], 32'h8000_0030, 7'h00, 1'b1,
                efr_pkg::t_efr_result'{1'b1, 1'b0, 8'd0, 8'h00});
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int sel;
        bit paused;
        link_ms = $urandom;
        paused  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        foreach (dir_rows[k])
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        items_sent = 0;

        // phase 0 runs on the reset timeout; the rest rewrite it
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: write_gap_timeout(16'hFFFF);
                2: write_gap_timeout(16'd1);
                3: write_gap_timeout(16'($urandom_range(2, 2000)));
                4: write_gap_timeout(16'($urandom_range(20, 300)));
                default: ;
            endcase
            // receiver holds off while frames keep coming
            if (ph == 1)
                hold_req <= 1'b1;
            while (items_sent < (ph + 1) * RANDOM_ITEMS / PHASES) begin
                sender_idle = (ph != PHASES - 1) && ($urandom_range(0, 4) != 0);
                stall_enable <= sender_idle;
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    send_frame();
                else if (sel < 85)
                    send_reads($urandom_range(1, 3));
                else
                    repeat ($urandom_range(1, 4)) begin
                        link_ms = link_ms + $urandom_range(0, gap_ms);
                        send_link(($urandom_range(0, 2) == 0) ? efr_pkg::ESC_BYTE :
                                                                8'($urandom));
                    end
                // sender goes quiet until the result stream is empty
                if (ph == 1 && !paused && items_sent >= 3 * RANDOM_ITEMS / (2 * PHASES)) begin
                    paused = 1'b1;
                    wait_drain();
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/efr_pkg.sv
rtl/efr_frame_core.sv
rtl/escaped_frame_receiver_unit.sv
tb/sv/escaped_frame_receiver_unit_tb.sv
